[hw/rtl/smbcp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SPI memory bridge command parser package
// Shared constants and the operation code passed from parser to executor.
// ----------------------------------------------------------------------------
package smbcp_pkg;

  localparam int unsigned AddrBitsDefault = 17;
  localparam int unsigned AddrMaxBits     = 22;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned QueueDepth      = 2;
  localparam int unsigned OpKindW         = 2;

  typedef enum logic [OpKindW-1:0] {
    OpNone  = 2'd0,
    OpRead  = 2'd1,
    OpWrite = 2'd2
  } op_kind_e;

endpackage
`default_nettype wire

[hw/rtl/smbcp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module smbcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/smbcp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Command parser front end
// Tracks the frame phase, address, data and pointer, and turns every byte
// into one memory operation for the executor.
// ----------------------------------------------------------------------------
module smbcp_front #(
  parameter int unsigned AddrBits = smbcp_pkg::AddrBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          frame_start_i,
  input  logic [smbcp_pkg::ByteW-1:0]   rx_byte_i,
  output smbcp_pkg::op_kind_e           op_kind_o,
  output logic [AddrBits-1:0]           op_addr_o,
  output logic [smbcp_pkg::ByteW-1:0]   op_data_o
);
  import smbcp_pkg::*;

  typedef enum logic [2:0] {
    PhIdle,
    PhAddrHi,
    PhAddrLo,
    PhData,
    PhDone
  } phase_e;

  localparam logic [1:0] CmdWriteNext = 2'd0;
  localparam logic [1:0] CmdWriteAt   = 2'd1;
  localparam logic [1:0] CmdReadNext  = 2'd2;
  localparam logic [1:0] CmdReadAt    = 2'd3;

  phase_e              phase_q, phase_d;
  logic [1:0]          cmd_q, cmd_d;
  logic [AddrBits-1:0] ptr_q, ptr_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [ByteW-1:0]    data_q, data_d;

  logic [AddrMaxBits-1:0] hi_wide;
  logic [AddrBits-1:0]    lo_addr;

  assign hi_wide = {rx_byte_i[5:0], 16'h0000};
  assign lo_addr = addr_q | AddrBits'(rx_byte_i);

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    ptr_d     = ptr_q;
    addr_d    = addr_q;
    data_d    = data_q;
    op_kind_o = OpNone;
    op_addr_o = ptr_q;
    op_data_o = rx_byte_i;
    if (frame_start_i) begin
      cmd_d  = rx_byte_i[7:6];
      addr_d = hi_wide[AddrBits-1:0];
      case (rx_byte_i[7:6])
        CmdReadAt: begin
          phase_d = PhAddrHi;
        end
        CmdReadNext: begin
          op_kind_o = OpRead;
          ptr_d     = ptr_q + AddrBits'(1);
          phase_d   = PhDone;
        end
        default: begin
          phase_d = PhData;
        end
      endcase
    end else begin
      case (phase_q)
        PhData: begin
          data_d = rx_byte_i;
          if (cmd_q == CmdWriteNext) begin
            op_kind_o = OpWrite;
            ptr_d     = ptr_q + AddrBits'(1);
            phase_d   = PhDone;
          end else begin
            phase_d = PhAddrHi;
          end
        end
        PhAddrHi: begin
          addr_d  = addr_q | (AddrBits'(rx_byte_i) << 8);
          phase_d = PhAddrLo;
        end
        PhAddrLo: begin
          addr_d = lo_addr;
          if (cmd_q == CmdWriteAt) begin
            op_kind_o = OpWrite;
            op_addr_o = lo_addr;
            op_data_o = data_q;
            ptr_d     = lo_addr + AddrBits'(1);
          end else begin
            ptr_d = lo_addr;
          end
          phase_d = PhDone;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cmd_q   <= CmdWriteNext;
      ptr_q   <= '0;
      addr_q  <= '0;
      data_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      ptr_q   <= ptr_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/smbcp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Operation queue
// Small register FIFO between the parser and the memory executor.
// ----------------------------------------------------------------------------
module smbcp_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = smbcp_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output logic [Width-1:0] head_data_o
);
  import smbcp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule
`default_nettype wire

[hw/rtl/smbcp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Memory executor back end
// Pops queued operations, accesses the byte memory and holds the result in
// an output register.
// ----------------------------------------------------------------------------
module smbcp_back #(
  parameter int unsigned AddrBits = smbcp_pkg::AddrBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  smbcp_pkg::op_kind_e         head_kind_i,
  input  logic [AddrBits-1:0]         head_addr_i,
  input  logic [smbcp_pkg::ByteW-1:0] head_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [smbcp_pkg::ByteW-1:0] tx_byte_o,
  output logic                        read_valid_o,
  output logic                        wrote_o
);
  import smbcp_pkg::*;

  logic             s1_valid_q;
  op_kind_e         s1_kind_q;
  logic             s1_adv;
  logic [ByteW-1:0] rdata;

  logic             out_valid_q;
  logic [ByteW-1:0] tx_q;
  logic             rd_flag_q;
  logic             wr_flag_q;

  assign s1_adv = s1_valid_q && (!out_valid_q || out_ready_i);
  assign pop_o  = head_valid_i && (!s1_valid_q || s1_adv);

  smbcp_ram #(
    .Width (ByteW),
    .Depth (2 ** AddrBits)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (pop_o),
    .we_i    (head_kind_i == OpWrite),
    .addr_i  (head_addr_i),
    .wdata_i (head_data_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_kind_q   <= OpNone;
      out_valid_q <= 1'b0;
      tx_q        <= '0;
      rd_flag_q   <= 1'b0;
      wr_flag_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
        s1_kind_q  <= head_kind_i;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        tx_q        <= (s1_kind_q == OpRead) ? rdata : '0;
        rd_flag_q   <= (s1_kind_q == OpRead);
        wr_flag_q   <= (s1_kind_q == OpWrite);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_byte_o    = tx_q;
  assign read_valid_o = rd_flag_q;
  assign wrote_o      = wr_flag_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(rd_flag_q && wr_flag_q))
    else $error("read and write flags both set");

  a_tx_zero_unless_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rd_flag_q) |-> (tx_q == '0))
    else $error("tx byte nonzero without read data");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> s1_valid_q)
    else $error("memory stage dropped while output stalled");

endmodule
`default_nettype wire

[hw/rtl/spi_memory_bridge_command_parser_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SPI memory bridge command parser
// Target side of a chip-select-framed SPI byte protocol over a byte memory.
// ----------------------------------------------------------------------------
// Each received byte (tuser[0] marks the first byte of a frame) yields exactly
// one result transaction: the memory byte for a read-next command, a wrote
// flag when the byte completes a write, otherwise zeros. One byte is taken
// per clock cycle when the output is not backpressured; each result passes
// through the queue slot, the memory read register and the output register.
// The single-port byte memory, one access per cycle, sets the rate. The
// memory has no reset; reading a never-written byte returns an undefined
// value.
// ----------------------------------------------------------------------------
module spi_memory_bridge_command_parser_unit #(
  parameter int unsigned AddrBits = smbcp_pkg::AddrBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [smbcp_pkg::ByteW-1:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic                        s_axis_tuser,   // [0] frame_start
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [smbcp_pkg::ByteW-1:0] m_axis_tdata,   // [7:0] tx_byte
  output logic [1:0]                  m_axis_tuser    // [0] read_valid, [1] wrote
);
  import smbcp_pkg::*;

  localparam int unsigned EntryW = OpKindW + ByteW + AddrBits;

  logic                accept;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  logic [EntryW-1:0]   q_head;
  op_kind_e            f_kind;
  logic [AddrBits-1:0] f_addr;
  logic [ByteW-1:0]    f_data;
  logic                read_valid;
  logic                wrote;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && !q_full;

  smbcp_front #(
    .AddrBits (AddrBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_start_i (s_axis_tuser),
    .rx_byte_i     (s_axis_tdata),
    .op_kind_o     (f_kind),
    .op_addr_o     (f_addr),
    .op_data_o     (f_data)
  );

  smbcp_queue #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_data_i  ({f_kind, f_data, f_addr}),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_valid),
    .head_data_o  (q_head)
  );

  smbcp_back #(
    .AddrBits (AddrBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_kind_i  (op_kind_e'(q_head[EntryW-1 -: OpKindW])),
    .head_addr_i  (q_head[AddrBits-1:0]),
    .head_data_i  (q_head[AddrBits +: ByteW]),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .tx_byte_o    (m_axis_tdata),
    .read_valid_o (read_valid),
    .wrote_o      (wrote)
  );

  assign m_axis_tuser = {wrote, read_valid};

endmodule
`default_nettype wire
